@@ hw/rtl/sll_pkg.sv @@
// Shared constants and codes for the static linked list engine.
// No dependencies; sll_if and the engine import this package.
package sll_pkg;

    localparam int SLL_TOTAL_SLOTS = 16;

    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int LEN_W = 4;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

@@ hw/rtl/sll_if.sv @@
// Valid/ready channel interfaces for the command and response beats.
// Depends on sll_pkg for the field widths.
interface sll_cmd_if
    import sll_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface sll_rsp_if
    import sll_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] out_value;
    logic [LEN_W-1:0]        length;

    modport source (output valid, status, out_value, length, input ready);
    modport sink   (input valid, status, out_value, length, output ready);
endinterface

@@ hw/rtl/sll_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/static_linked_list_engine.sv @@
// Top level of the static linked list engine: sequencer, cursor walk and free-slot scan.
// Depends on sll_pkg, sll_if (sll_cmd_if, sll_rsp_if) and sll_ram.
//
// Channel   Dir  Beat fields                   Accepted when
// i_cmd     in   command, position, value      valid && ready
// o_rsp     out  status, out_value, length     valid && ready
//
// Insert first scans the used bits for the lowest free slot and then walks to the
// position; delete and read only walk; a rejected command goes straight to the response.
// The walk follows one next-slot cursor per cycle through the cursor RAM read port,
// and the free-slot scan reads one used bit per cycle.
// After reset a clearing pass over all TOTAL_SLOTS slots zeroes the used bits; no command
// is taken meanwhile. A held response stalls only the final load, not the command work.
module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int TOTAL_SLOTS = SLL_TOTAL_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sll_cmd_if.sink    i_cmd,
    sll_rsp_if.source  o_rsp
);
    localparam int AW   = $clog2(TOTAL_SLOTS);
    localparam int CW   = $clog2(TOTAL_SLOTS);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [AW-1:0] SLOT_HEAD = '0;
    localparam logic [AW-1:0] SLOT_ONE  = AW'(1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(TOTAL_SLOTS - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(TOTAL_SLOTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_INS_B = 3'd4;
    localparam logic [2:0] S_TGT   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]       r_state,  n_state;
    logic [CW-1:0]    r_count,  n_count;
    logic [AW-1:0]    r_slot,   n_slot;
    logic [AW-1:0]    r_ptr,    n_ptr;
    logic [AW-1:0]    r_target, n_target;
    logic [POS_W-1:0] r_steps,  n_steps;
    logic [CMD_W-1:0] r_cmd,    n_cmd;
    logic [VAL_W-1:0] r_value,  n_value;
    logic [STS_W-1:0] r_status, n_status;
    logic [VAL_W-1:0] r_result, n_result;

    logic             r_out_valid;
    logic [STS_W-1:0] r_out_status;
    logic [VAL_W-1:0] r_out_value;
    logic [LEN_W-1:0] r_out_len;

    // RAM ports
    logic             w_elem_we, w_next_we, w_used_we;
    logic [AW-1:0]    w_elem_waddr, w_next_waddr, w_used_waddr;
    logic [VAL_W-1:0] w_elem_wdata, w_elem_rdata;
    logic [AW-1:0]    w_next_wdata, w_next_rdata;
    logic [0:0]       w_used_wdata, w_used_rdata;
    logic [AW-1:0]    w_next_raddr, w_used_raddr;

    logic             w_accept;
    logic             w_load;
    logic [CMPW-1:0]  w_pos_x, w_cnt_x;
    logic [CW+LEN_W-1:0] w_cnt_pad;

    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign w_load    = (r_state == S_RESP) && (!r_out_valid || o_rsp.ready);
    assign w_pos_x   = {{(CMPW-POS_W){1'b0}}, i_cmd.position};
    assign w_cnt_x   = {{(CMPW-CW){1'b0}}, r_count};
    assign w_cnt_pad = {{LEN_W{1'b0}}, r_count};

    // The cursor read port follows the chain: during the walk the address is the
    // cursor now on the read port, otherwise the head.
    assign w_next_raddr = (r_state == S_WALK) ? w_next_rdata : SLOT_HEAD;
    assign w_used_raddr = (r_state == S_SCAN) ? (r_slot + SLOT_ONE) : SLOT_ONE;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_slot   = r_slot;
        n_ptr    = r_ptr;
        n_target = r_target;
        n_steps  = r_steps;
        n_cmd    = r_cmd;
        n_value  = r_value;
        n_status = r_status;
        n_result = r_result;

        w_elem_we    = 1'b0;
        w_elem_waddr = r_slot;
        w_elem_wdata = r_value;
        w_next_we    = 1'b0;
        w_next_waddr = r_slot;
        w_next_wdata = w_next_rdata;
        w_used_we    = 1'b0;
        w_used_waddr = r_slot;
        w_used_wdata = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_used_we    = 1'b1;
                w_used_waddr = r_slot;
                w_used_wdata = 1'b0;
                n_slot       = r_slot + SLOT_ONE;
                if (r_slot == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_cmd.command;
                    n_value  = i_cmd.value;
                    n_result = '0;
                    n_steps  = i_cmd.position - POS_W'(1);
                    n_ptr    = SLOT_HEAD;
                    n_slot   = SLOT_ONE;
                    n_status = ST_BADPOS;
                    n_state  = S_RESP;
                    case (i_cmd.command)
                        CMD_INSERT: begin
                            if (i_cmd.position == '0 || w_pos_x > w_cnt_x + CMPW'(1)) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_DELETE, CMD_READ: begin
                            if (i_cmd.position == '0) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos_x > w_cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The used bit of r_slot is on the read port; the list is not full,
                // so a free slot turns up before the end of the array.
                if (w_used_rdata == 1'b0) begin
                    n_state = S_WALK;
                end else begin
                    n_slot = r_slot + SLOT_ONE;
                end
            end
            S_WALK: begin
                if (r_steps != '0) begin
                    n_ptr   = w_next_rdata;
                    n_steps = r_steps - POS_W'(1);
                end else if (r_cmd == CMD_INSERT) begin
                    // The new slot inherits the cursor of its predecessor.
                    w_elem_we    = 1'b1;
                    w_elem_waddr = r_slot;
                    w_elem_wdata = r_value;
                    w_next_we    = 1'b1;
                    w_next_waddr = r_slot;
                    w_next_wdata = w_next_rdata;
                    w_used_we    = 1'b1;
                    w_used_waddr = r_slot;
                    w_used_wdata = 1'b1;
                    n_state      = S_INS_B;
                end else begin
                    n_target = w_next_rdata;
                    n_state  = S_TGT;
                end
            end
            S_INS_B: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_ptr;
                w_next_wdata = r_slot;
                n_count      = r_count + CW'(1);
                n_status     = ST_OK;
                n_state      = S_RESP;
            end
            S_TGT: begin
                n_result = w_elem_rdata;
                n_status = ST_OK;
                n_state  = S_RESP;
                if (r_cmd == CMD_DELETE) begin
                    w_next_we    = 1'b1;
                    w_next_waddr = r_ptr;
                    w_next_wdata = w_next_rdata;
                    w_used_we    = 1'b1;
                    w_used_waddr = r_target;
                    w_used_wdata = 1'b0;
                    n_count      = r_count - CW'(1);
                end
            end
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_slot  <= n_slot;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_target <= n_target;
        r_steps  <= n_steps;
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_status <= n_status;
        r_result <= n_result;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_value  <= r_result;
            r_out_len    <= w_cnt_pad[LEN_W-1:0];
        end
    end

    sll_ram #(.WIDTH(VAL_W), .DEPTH(TOTAL_SLOTS)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_elem_we),
        .i_waddr (w_elem_waddr),
        .i_wdata (w_elem_wdata),
        .i_raddr (w_next_rdata),
        .o_rdata (w_elem_rdata)
    );

    sll_ram #(.WIDTH(AW), .DEPTH(TOTAL_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_next_raddr),
        .o_rdata (w_next_rdata)
    );

    sll_ram #(.WIDTH(1), .DEPTH(TOTAL_SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (w_used_raddr),
        .o_rdata (w_used_rdata)
    );

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_value = r_out_value;
    assign o_rsp.length    = r_out_len;

`ifndef SYNTHESIS
    // A command beat is never followed by another in the very next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_cmd.ready)
        else $error("command accepted while previous command in progress");

    // Linking a new slot grows the list by exactly one element.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_B) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the element count by one");

    // A full status is only reported when every slot above the head is linked.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_status == ST_FULL) |-> (r_count == CNT_FULL))
        else $error("full status with free slots left");

    // After a delete the list holds fewer elements than there are slots above the head.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TGT && r_cmd == CMD_DELETE) |=> (r_count < CNT_FULL))
        else $error("element count out of range after delete");
`endif
endmodule
